### rtl/core/xs128p_pkg.sv
`default_nettype none
package xs128p_pkg;

  // xorshift128+ reset words
  localparam logic [63:0] RESET_A = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] RESET_B = 64'hBF58_476D_1CE4_E5B9;

  // splitmix64 constants
  localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL1   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL2   = 64'h94D0_49BB_1331_11EB;

  // command codes (bit 0 of the command field)
  localparam logic CMD_NEXT   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  // multiplier request / response
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_MIX   = 7'b000_0010,
    S_MUL1  = 7'b000_0100,
    S_MUL2  = 7'b000_1000,
    S_CHECK = 7'b001_0000,
    S_WARM  = 7'b010_0000,
    S_DONE  = 7'b100_0000
  } state_t;

endpackage
`default_nettype wire

### rtl/core/xs128p_step.sv
`default_nettype none
module xs128p_step (
  input  wire logic [63:0] word_a,
  input  wire logic [63:0] word_b,
  output logic      [63:0] word_a_nxt,
  output logic      [63:0] word_b_nxt,
  output logic      [63:0] value
);

  logic [63:0] x1;
  logic [63:0] x2;

  always_comb begin
    x1         = word_a ^ (word_a << 23);
    x2         = x1 ^ (x1 >> 17);
    word_b_nxt = x2 ^ word_b ^ (word_b >> 26);
    word_a_nxt = word_b;
    value      = word_b_nxt + word_b;
  end

endmodule
`default_nettype wire

### rtl/core/xs128p_mul.sv
`default_nettype none
// 64x64 -> low 64 bits, one 32x32 product per cycle while busy.
module xs128p_mul (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire xs128p_pkg::mul_req_t req,
  output xs128p_pkg::mul_rsp_t      rsp
);

  localparam logic [1:0] PH_LL   = 2'd0;
  localparam logic [1:0] PH_LH   = 2'd1;
  localparam logic [1:0] PH_HL   = 2'd2;
  localparam logic [1:0] PH_LAST = 2'd3;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [1:0]  pph_r, pph_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] opa, opb;

  always_comb begin
    case (ph_r)
      PH_LL:   begin opa = a_r[31:0];  opb = b_r[31:0];  end
      PH_LH:   begin opa = a_r[31:0];  opb = b_r[63:32]; end
      PH_HL:   begin opa = a_r[63:32]; opb = b_r[31:0];  end
      default: begin opa = a_r[31:0];  opb = b_r[31:0];  end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ph_nxt   = ph_r;
    pph_nxt  = pph_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      ph_nxt   = PH_LL;
      a_nxt    = req.a;
      b_nxt    = req.b;
    end else if (busy_r) begin
      if (ph_r != PH_LAST) begin
        prod_nxt = opa * opb;
        pph_nxt  = ph_r;
      end
      if (ph_r != PH_LL) begin
        // cross terms only feed the upper half
        if (pph_r == PH_LL) acc_nxt = prod_r;
        else                acc_nxt = acc_r + {prod_r[31:0], 32'd0};
      end
      if (ph_r == PH_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_LL;
      pph_r  <= PH_LL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
      pph_r  <= pph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule
`default_nettype wire

### rtl/core/xorshift128plus_generator_top.sv
`default_nettype none
// Channel   Direction  Ports                                 Beat meaning
// in_       input      in_valid in_ready in_command in_seed  one command
// out_      output     out_valid out_ready out_value         one 64-bit result
//
// A next command runs the xorshift step combinationally from the state
// words into the output register, so next beats flow one a cycle while
// out_ready keeps the slot free. A reseed runs splitmix64 twice on the
// shared iterative multiplier (two multiplies per word), then one
// warm-up step per cycle, before its zero result and the next beat.
// Synchronous active-low reset loads the reset words; no clearing pass.
// A result waiting on out_ready holds in_ready low until it drains, for a
// reseed as well; a finished reseed waits in S_DONE for the output slot.
module xorshift128plus_generator_top #(
  parameter int WARMUP_STEPS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [63:0] in_seed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] out_value
);

  localparam int CNT_W = $clog2(WARMUP_STEPS + 2);

  xs128p_pkg::state_t   state_r, state_nxt;
  logic [63:0]          word_a_r, word_a_nxt;
  logic [63:0]          word_b_r, word_b_nxt;
  logic [63:0]          mix_r, mix_nxt;     // splitmix64 running sum
  logic                 idx_r, idx_nxt;     // which word is being mixed
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;     // warm-up steps left
  logic                 out_valid_r, out_valid_nxt;
  logic [63:0]          out_value_r, out_value_nxt;

  logic [63:0]          step_a, step_b, step_value;
  logic [63:0]          mixed;
  logic                 slot_free;
  xs128p_pkg::mul_req_t mul_req;
  xs128p_pkg::mul_rsp_t mul_rsp;

  xs128p_step u_step (
    .word_a     (word_a_r),
    .word_b     (word_b_r),
    .word_a_nxt (step_a),
    .word_b_nxt (step_b),
    .value      (step_value)
  );

  xs128p_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // output slot is free if empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == xs128p_pkg::S_IDLE) && slot_free;
  assign mixed     = mul_rsp.product ^ (mul_rsp.product >> 31);

  always_comb begin
    state_nxt     = state_r;
    word_a_nxt    = word_a_r;
    word_b_nxt    = word_b_r;
    mix_nxt       = mix_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    mul_req.start = 1'b0;
    mul_req.a     = mix_r ^ (mix_r >> 30);
    mul_req.b     = xs128p_pkg::MIX_MUL1;

    case (state_r)
      xs128p_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_command == xs128p_pkg::CMD_RESEED) begin
            mix_nxt   = in_seed;
            idx_nxt   = 1'b0;
            state_nxt = xs128p_pkg::S_MIX;
          end else begin
            word_a_nxt    = step_a;
            word_b_nxt    = step_b;
            out_valid_nxt = 1'b1;
            out_value_nxt = step_value;
          end
        end
      end
      xs128p_pkg::S_MIX: begin
        // z ^ (z >> 30) into the first multiply
        mul_req.start = 1'b1;
        mix_nxt       = mix_r + xs128p_pkg::MIX_GOLDEN;
        state_nxt     = xs128p_pkg::S_MUL1;
      end
      xs128p_pkg::S_MUL1: begin
        mul_req.a = mul_rsp.product ^ (mul_rsp.product >> 27);
        mul_req.b = xs128p_pkg::MIX_MUL2;
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          state_nxt     = xs128p_pkg::S_MUL2;
        end
      end
      xs128p_pkg::S_MUL2: begin
        if (mul_rsp.done) begin
          if (!idx_r) begin
            word_a_nxt = mixed;
            idx_nxt    = 1'b1;
            state_nxt  = xs128p_pkg::S_MIX;
          end else begin
            word_b_nxt = mixed;
            state_nxt  = xs128p_pkg::S_CHECK;
          end
        end
      end
      xs128p_pkg::S_CHECK: begin
        // all-zero state would lock up the generator
        if (word_a_r == 64'd0 && word_b_r == 64'd0) begin
          word_a_nxt = xs128p_pkg::RESET_A;
          word_b_nxt = xs128p_pkg::RESET_B;
        end
        cnt_nxt = CNT_W'(WARMUP_STEPS);
        if (WARMUP_STEPS == 0) state_nxt = xs128p_pkg::S_DONE;
        else                   state_nxt = xs128p_pkg::S_WARM;
      end
      xs128p_pkg::S_WARM: begin
        word_a_nxt = step_a;
        word_b_nxt = step_b;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) state_nxt = xs128p_pkg::S_DONE;
      end
      xs128p_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = 64'd0;
          state_nxt     = xs128p_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = xs128p_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xs128p_pkg::S_IDLE;
      word_a_r    <= xs128p_pkg::RESET_A;
      word_b_r    <= xs128p_pkg::RESET_B;
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      word_a_r    <= word_a_nxt;
      word_b_r    <= word_b_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mix_r       <= mix_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // multiplier only answers while a mix multiply is outstanding
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == xs128p_pkg::S_MUL1 || state_r == xs128p_pkg::S_MUL2))
    else $error("multiplier done outside a multiply wait");

  // generator state never all zero while serving commands
  a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xs128p_pkg::S_IDLE) |-> ((word_a_r | word_b_r) != 64'd0))
    else $error("generator state is all zero");

  // reseed completion posts a zero result
  a_reseed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xs128p_pkg::S_DONE && slot_free)
      |=> (out_valid_r && out_value_r == 64'd0 && state_r == xs128p_pkg::S_IDLE))
    else $error("reseed did not post a zero result");

  // warm-up never runs with an empty count
  a_warm_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xs128p_pkg::S_WARM) |-> (cnt_r != '0))
    else $error("warm-up counter underflow");

endmodule
`default_nettype wire

### bench/xorshift128plus_generator_top_test.sv
`timescale 1ns / 1ps

module xorshift128plus_generator_top_test;

  // Warm-up length handed to the generator; set to 0 to run the
  // no-discard variant of reseeding.
  localparam int WARMUP       = 32;
  localparam int RANDOM_BEATS = 600;
  // Bound sized for the slowest beat (longest idle in, a full reseed with
  // warm-up, longest stall out) across every beat, with a wide margin.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24 + WARMUP + 40;

  typedef struct packed {
    logic        command;
    logic [63:0] seed;
  } cmd_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = xs128p_pkg::CMD_NEXT;
  logic [63:0] in_seed = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_value;

  xorshift128plus_generator_top #(
    .WARMUP_STEPS(WARMUP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .in_seed   (in_seed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------
  // Generator model: own copy of the two state words.
  // ---------------------------------------------------------------------
  logic [63:0] gen_s0 = xs128p_pkg::RESET_A;
  logic [63:0] gen_s1 = xs128p_pkg::RESET_B;
  int          next_cmds = 0;
  int          reseed_cmds = 0;

  // One xorshift128+ step; returns the sum of new and old second word.
  function automatic logic [63:0] xs_advance();
    logic [63:0] x;
    logic [63:0] y;
    x = gen_s0;
    y = gen_s1;
    gen_s0 = y;
    x = x ^ (x << 23);
    x = x ^ (x >> 17);
    x = x ^ y ^ (y >> 26);
    gen_s1 = x;
    return x + y;
  endfunction

  // splitmix64 output finaliser
  function automatic logic [63:0] mix64(logic [63:0] z);
    logic [63:0] m;
    m = (z ^ (z >> 30)) * xs128p_pkg::MIX_MUL1;
    m = (m ^ (m >> 27)) * xs128p_pkg::MIX_MUL2;
    return m ^ (m >> 31);
  endfunction

  function automatic void xs_reseed(logic [63:0] seed);
    gen_s0 = mix64(seed);
    gen_s1 = mix64(seed + xs128p_pkg::MIX_GOLDEN);
    // both words zero would lock the generator: fall back to reset words
    if (gen_s0 == '0 && gen_s1 == '0) begin
      gen_s0 = xs128p_pkg::RESET_A;
      gen_s1 = xs128p_pkg::RESET_B;
    end
    for (int n = 0; n < WARMUP; n++) begin
      void'(xs_advance());
    end
  endfunction

  // Result expected for one accepted command beat.
  function automatic logic [63:0] predict_value(logic command, logic [63:0] seed);
    if (command == xs128p_pkg::CMD_RESEED) begin
      reseed_cmds++;
      xs_reseed(seed);
      return '0;
    end
    next_cmds++;
    return xs_advance();
  endfunction

  // ---------------------------------------------------------------------
  // Queues and bookkeeping
  // ---------------------------------------------------------------------
  cmd_beat_t   pending_cmds[$];
  logic [63:0] predicted_values[$];
  int          mismatches = 0;
  int          results_seen = 0;

  task automatic report(string msg);
    mismatches++;
    $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic add_beat(logic command, logic [63:0] seed);
    cmd_beat_t b;
    b.command = command;
    b.seed    = seed;
    pending_cmds.push_back(b);
  endtask

  // Idle length per beat; a calm side never idles, which gives
  // back-to-back stretches between the noisy ones.
  function automatic int pause_len(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Seed mix: mostly random, with the corner patterns now and then.
  function automatic logic [63:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd0 - xs128p_pkg::MIX_GOLDEN;   // second splitmix word comes out zero
      3: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued command beats, idling between them.
  // in_valid gets exactly one NBA per edge so a beat held across an
  // accept never sees a low-high glitch.
  // ---------------------------------------------------------------------
  int in_gap  = 0;
  bit in_calm = 1'b0;

  always @(posedge clk) begin : drive
    logic      hold;
    cmd_beat_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid;
      if (in_valid && in_ready) begin
        predicted_values.push_back(predict_value(in_command, in_seed));
        hold = 1'b0;
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        in_gap = pause_len(in_calm);
      end
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_cmds.size() > 0) begin
          b = pending_cmds.pop_front();
          in_command <= b.command;
          in_seed    <= b.seed;
          hold = 1'b1;
        end
      end
      in_valid <= hold;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stalls the result channel and checks each beat in order.
  // ---------------------------------------------------------------------
  int out_stall = 0;
  bit out_calm  = 1'b0;

  always @(posedge clk) begin : watch
    logic        rdy;
    logic [63:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rdy = out_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_values.size() == 0) begin
          report($sformatf("result beat %h with nothing outstanding", out_value));
        end else begin
          want = predicted_values.pop_front();
          if (out_value !== want)
            report($sformatf("value %h, model says %h", out_value, want));
        end
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_stall = pause_len(out_calm);
        rdy = (out_stall == 0);
      end else if (!out_ready) begin
        if (out_stall > 0) out_stall--;
        rdy = (out_stall == 0);
      end
      out_ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic cmd;

    // Straight from reset: sequence must follow the reset words, and the
    // seed field must make no difference to next commands.
    add_beat(xs128p_pkg::CMD_NEXT, '0);
    add_beat(xs128p_pkg::CMD_NEXT, '1);
    add_beat(xs128p_pkg::CMD_NEXT, 64'hA5A5_5A5A_F0F0_0F0F);
    // Zero seed: first splitmix word is zero, second is not.
    add_beat(xs128p_pkg::CMD_RESEED, '0);
    add_beat(xs128p_pkg::CMD_NEXT, '1);
    add_beat(xs128p_pkg::CMD_NEXT, '0);
    add_beat(xs128p_pkg::CMD_RESEED, '1);
    add_beat(xs128p_pkg::CMD_NEXT, 64'h5555_5555_5555_5555);
    // Seed that wraps to zero on the second splitmix draw. Both words
    // zero at once cannot happen, since splitmix only maps zero to zero.
    add_beat(xs128p_pkg::CMD_RESEED, 64'd0 - xs128p_pkg::MIX_GOLDEN);
    add_beat(xs128p_pkg::CMD_NEXT, '0);
    add_beat(xs128p_pkg::CMD_NEXT, '0);
    // back-to-back reseeds, then a run of nexts
    add_beat(xs128p_pkg::CMD_RESEED, 64'd1);
    add_beat(xs128p_pkg::CMD_RESEED, 64'h8000_0000_0000_0000);
    add_beat(xs128p_pkg::CMD_NEXT, '0);
    add_beat(xs128p_pkg::CMD_NEXT, '1);
    add_beat(xs128p_pkg::CMD_NEXT, '0);
    add_beat(xs128p_pkg::CMD_RESEED, 64'h5555_5555_5555_5555);
    add_beat(xs128p_pkg::CMD_NEXT, '0);
    add_beat(xs128p_pkg::CMD_RESEED, 64'hAAAA_AAAA_AAAA_AAAA);
    add_beat(xs128p_pkg::CMD_NEXT, 64'hAAAA_AAAA_AAAA_AAAA);

    // Random part: mostly next beats, a reseed roughly one in twelve.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      cmd = ($urandom_range(0, 11) == 0) ? xs128p_pkg::CMD_RESEED : xs128p_pkg::CMD_NEXT;
      add_beat(cmd, pick_seed());
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid || predicted_values.size() != 0)
      @(posedge clk);
    // let any stray result beat show itself
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (predicted_values.size() != 0)
      report($sformatf("%0d results never arrived", predicted_values.size()));

    $display("Ran %0d next and %0d reseed commands (warm-up %0d steps),",
             next_cmds, reseed_cmds, WARMUP);
    $display("with random idling on both sides; %0d results checked, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles, %0d results still outstanding",
             CYCLE_LIMIT, predicted_values.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
